>>> src/sha1_stream_hasher_assert.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SHA1S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA1S_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SHA1S_ASSERT(lbl, prop, msg)
`define SHA1S_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/sha1s_pkg.sv
package sha1s_pkg;

  localparam logic [31:0] SHA1_K0 = 32'h5a827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ed9eba1;
  localparam logic [31:0] SHA1_K2 = 32'h8f1bbcdc;
  localparam logic [31:0] SHA1_K3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  typedef logic [4:0][31:0] chain_t;

  // index 0 holds h0
  localparam chain_t SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       msg_end;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctl_t;

  typedef struct packed {
    logic step;
    logic done;
  } rnd_sts_t;

endpackage

>>> src/sha1s_sched.sv
module sha1s_sched (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [7:0]  shift_byte,
  input  logic        step_en,
  output logic [31:0] w_out
);
  import sha1s_pkg::*;

  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  mix_w;
  logic [31:0]  new_w;

  // oldest word sits at the top: W[t] = win_r[511:480]
  assign mix_w = win_r[447:416] ^ win_r[255:224] ^ win_r[95:64] ^ win_r[511:480];
  assign new_w = {mix_w[30:0], mix_w[31]};
  assign w_out = win_r[511:480];

  always_comb begin
    win_nxt = win_r;
    if (step_en) begin
      win_nxt = {win_r[479:0], new_w};
    end else if (shift_en) begin
      win_nxt = {win_r[503:0], shift_byte};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

>>> src/sha1s_round.sv
`include "sha1_stream_hasher_assert.svh"

module sha1s_round (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1s_pkg::rnd_ctl_t ctl,
  input  logic [31:0]        w_in,
  output sha1s_pkg::rnd_sts_t sts,
  output sha1s_pkg::chain_t   chain
);
  import sha1s_pkg::*;

  chain_t      chain_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        active_r;
  logic        add_r;
  logic [31:0] f_w;
  logic [31:0] k_w;
  logic [31:0] nx_w;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_w = (b_r & c_r) | (~b_r & d_r);
      k_w = SHA1_K0;
    end else if (rnd_r < 7'd40) begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = SHA1_K1;
    end else if (rnd_r < 7'd60) begin
      f_w = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_w = SHA1_K2;
    end else begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = SHA1_K3;
    end
    nx_w = {a_r[26:0], a_r[31:27]} + f_w + e_r + k_w + w_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r  <= SHA1_IV;
      rnd_r    <= 7'd0;
      active_r <= 1'b0;
      add_r    <= 1'b0;
    end else begin
      add_r <= 1'b0;
      if (ctl.init) begin
        chain_r <= SHA1_IV;
      end else if (add_r) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (ctl.start) begin
        active_r <= 1'b1;
        rnd_r    <= 7'd0;
      end else if (active_r) begin
        if (rnd_r == 7'd79) begin
          active_r <= 1'b0;
          add_r    <= 1'b1;
        end
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (active_r) begin
      a_r <= nx_w;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign sts.step = active_r;
  assign sts.done = add_r;
  assign chain    = chain_r;

  `SHA1S_NEVER(a_start_busy, ctl.start && (active_r || add_r), "start while compressing")
  `SHA1S_NEVER(a_step_done, active_r && add_r, "round step during chain add")
  `SHA1S_ASSERT(a_last_round, (active_r && rnd_r == 7'd79 && !ctl.start) |=> add_r, "no add after last round")

endmodule

>>> src/sha1_stream_hasher.sv
// SHA-1 hasher for a byte stream.
// Input channel (in_valid/in_stall/in_data): one beat carries an optional
// message byte and an optional end-of-message mark; a beat with both takes
// the byte as the last of the message. A beat with neither does nothing.
// A byte is taken only while the block is idle. Every 64th byte
// starts a compression: 80 rounds on the single round unit plus load and
// add, during which in_stall stays high. On end of message the tail is
// padded one byte per cycle outside compressions (0x80, zeros, 64-bit
// bit length), with one or two compressions.
// Output channel (out_valid/out_stall/out_data) then gives five beats,
// h0..h4, last_word set on h4; a stalled beat holds. After the fifth beat
// the block returns to the initial chain values and takes a new message.
// rst_n (synchronous, active low) restores the initial chain values and
// drops any message in progress.
`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1s_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1s_pkg::out_beat_t out_data
);
  import sha1s_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic        mark_r, mark_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        pad_r, pad_nxt;
  logic        final_r, final_nxt;
  logic        start_r, start_nxt;
  logic        init_r, init_nxt;
  logic [2:0]  widx_r, widx_nxt;

  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [31:0] w_word;
  rnd_ctl_t    ctl;
  rnd_sts_t    sts;
  chain_t      chain;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bitcnt_nxt = bitcnt_r;
    mark_nxt   = mark_r;
    len_ok_nxt = len_ok_r;
    pad_nxt    = pad_r;
    final_nxt  = final_r;
    widx_nxt   = widx_r;
    start_nxt  = 1'b0;
    init_nxt   = 1'b0;
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_valid) begin
            shift_en   = 1'b1;
            shift_byte = in_data.msg_byte;
            fill_nxt   = fill_r + 6'd1;
            bitcnt_nxt = bitcnt_r + 64'd8;
          end
          if (in_data.msg_end) begin
            pad_nxt  = 1'b1;
            mark_nxt = 1'b1;
          end
          if (in_data.byte_valid && fill_r == 6'd63) begin
            state_nxt = S_COMP;
            start_nxt = 1'b1;
          end else if (in_data.msg_end) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        shift_en = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (mark_r) begin
          shift_byte = PAD_MARK;
          mark_nxt   = 1'b0;
          len_ok_nxt = (fill_r < 6'd56);
        end else if (fill_r >= 6'd56 && len_ok_r) begin
          shift_byte = bitcnt_r[63:56];
          bitcnt_nxt = {bitcnt_r[55:0], 8'h00};
        end
        if (fill_r == 6'd63) begin
          state_nxt  = S_COMP;
          start_nxt  = 1'b1;
          len_ok_nxt = 1'b1;
          final_nxt  = len_ok_r && !mark_r;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          if (final_r) begin
            state_nxt = S_OUT;
            widx_nxt  = 3'd0;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (widx_r == 3'd4) begin
            state_nxt  = S_IDLE;
            init_nxt   = 1'b1;
            bitcnt_nxt = 64'd0;
            pad_nxt    = 1'b0;
            final_nxt  = 1'b0;
            len_ok_nxt = 1'b0;
            mark_nxt   = 1'b0;
            fill_nxt   = 6'd0;
          end else begin
            widx_nxt = widx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 6'd0;
      bitcnt_r <= 64'd0;
      mark_r   <= 1'b0;
      len_ok_r <= 1'b0;
      pad_r    <= 1'b0;
      final_r  <= 1'b0;
      start_r  <= 1'b0;
      init_r   <= 1'b0;
      widx_r   <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bitcnt_r <= bitcnt_nxt;
      mark_r   <= mark_nxt;
      len_ok_r <= len_ok_nxt;
      pad_r    <= pad_nxt;
      final_r  <= final_nxt;
      start_r  <= start_nxt;
      init_r   <= init_nxt;
      widx_r   <= widx_nxt;
    end
  end

  assign ctl.start = start_r;
  assign ctl.init  = init_r;

  sha1s_sched u_sched (
    .clk        (clk),
    .shift_en   (shift_en),
    .shift_byte (shift_byte),
    .step_en    (sts.step),
    .w_out      (w_word)
  );

  sha1s_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w_in  (w_word),
    .sts   (sts),
    .chain (chain)
  );

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_data.digest_word = chain[widx_r];
  assign out_data.last_word   = (widx_r == 3'd4);

  `SHA1S_NEVER(a_out_fill, out_valid && fill_r != 6'd0, "digest beat with partial block")
  `SHA1S_NEVER(a_done_state, sts.done && state_r != S_COMP, "compression done outside wait")
  `SHA1S_NEVER(a_final_pad, final_r && !pad_r, "final block without message end")

endmodule
